[rtl/fct_pkg.sv]
package fct_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int NUM_PLANES  = 6;
	localparam int NORM_W      = 12;
	localparam int NORM_FRAC   = 10;
	localparam int OFFS_W      = 28;
	localparam int REG_W       = 64;
	localparam int IDX_W       = 3;
	localparam int PROD_W      = NORM_W + COORD_WIDTH;
	localparam int SUM3_W      = PROD_W + 2;
	localparam int OFFS_SC_W   = OFFS_W + NORM_FRAC;
	localparam int DIST_W      = ((SUM3_W > OFFS_SC_W) ? SUM3_W : OFFS_SC_W) + 1;
	localparam int FIFO_AW     = 2;
	localparam int FIFO_DEPTH  = 1 << FIFO_AW;

	localparam logic [NUM_PLANES-1:0] FLAGS_ALL = '1;

	typedef enum logic [1:0] {
		FUNC_SPHERE = 2'd0,
		FUNC_BOX    = 2'd1,
		FUNC_POINT  = 2'd2,
		FUNC_IGNORE = 2'd3
	} func_t;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	// Field order follows the register packing, most significant first.
	typedef struct packed {
		logic signed [OFFS_W-1:0] d;
		logic signed [NORM_W-1:0] nz;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nx;
	} plane_t;

	typedef struct packed {
		func_t                  func;
		coord_t                 px;
		coord_t                 py;
		coord_t                 pz;
		coord_t                 hx;
		coord_t                 hy;
		coord_t                 hz;
		logic [COORD_WIDTH-2:0] radius;
		logic                   last;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

endpackage

[rtl/fct_front.sv]
module fct_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  fct_pkg::item_t  in_item,
	output fct_pkg::q_head_t head,
	input  logic            pop
);

	fct_pkg::item_t               mem_q [fct_pkg::FIFO_DEPTH];
	logic [fct_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [fct_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [fct_pkg::FIFO_AW:0]    count_q;
	logic                         push;

	// Items with the unused selector are taken and dropped here.
	assign in_stall = (count_q == (fct_pkg::FIFO_AW + 1)'(fct_pkg::FIFO_DEPTH));
	assign push = in_valid && !in_stall && (in_item.func != fct_pkg::FUNC_IGNORE);

	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/fct_back.sv]
module fct_back (
	input  logic             clk,
	input  logic             arst_n,
	input  fct_pkg::plane_t  planes [fct_pkg::NUM_PLANES],
	input  fct_pkg::q_head_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             culled
);

	logic en;

	logic signed [fct_pkg::NORM_W-1:0] norm [fct_pkg::NUM_PLANES][3];
	fct_pkg::coord_t                   lo [3];
	fct_pkg::coord_t                   hi [3];
	logic signed [fct_pkg::PROD_W-1:0] prod_c [fct_pkg::NUM_PLANES][3];

	logic                              valid_s1;
	fct_pkg::func_t                    func_s1;
	logic                              last_s1;
	logic [fct_pkg::COORD_WIDTH-2:0]   rad_s1;
	logic signed [fct_pkg::PROD_W-1:0] prod_s1 [fct_pkg::NUM_PLANES][3];

	logic signed [fct_pkg::DIST_W-1:0] dist_c [fct_pkg::NUM_PLANES];
	logic signed [fct_pkg::DIST_W-1:0] rad_sc;
	logic [fct_pkg::NUM_PLANES-1:0]    hit_c;

	logic                              valid_s2;
	fct_pkg::func_t                    func_s2;
	logic                              last_s2;
	logic [fct_pkg::NUM_PLANES-1:0]    hit_s2;

	logic [fct_pkg::NUM_PLANES-1:0]    flags_q;
	logic [fct_pkg::NUM_PLANES-1:0]    flags_nxt;
	logic                              out_valid_q;
	logic                              culled_q;

	assign en  = !(out_valid_q && out_stall);
	assign pop = en && head.valid;

	// Stage one: corner selection and the per-axis products.
	always_comb begin
		fct_pkg::coord_t sel;
		sel = '0;
		lo[0] = head.item.px;
		lo[1] = head.item.py;
		lo[2] = head.item.pz;
		hi[0] = head.item.hx;
		hi[1] = head.item.hy;
		hi[2] = head.item.hz;
		for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
			norm[i][0] = planes[i].nx;
			norm[i][1] = planes[i].ny;
			norm[i][2] = planes[i].nz;
			for (int k = 0; k < 3; k++) begin
				sel = ((head.item.func == fct_pkg::FUNC_BOX) && (norm[i][k] <= 0))
					? hi[k] : lo[k];
				prod_c[i][k] = fct_pkg::PROD_W'(norm[i][k]) * fct_pkg::PROD_W'(sel);
			end
		end
	end

	// Stage two: plane distances and the per-plane tests.
	always_comb begin
		rad_sc = fct_pkg::DIST_W'(rad_s1) << fct_pkg::NORM_FRAC;
		for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
			dist_c[i] = fct_pkg::DIST_W'(prod_s1[i][0]) + fct_pkg::DIST_W'(prod_s1[i][1])
				+ fct_pkg::DIST_W'(prod_s1[i][2])
				+ (fct_pkg::DIST_W'(planes[i].d) <<< fct_pkg::NORM_FRAC);
			unique case (func_s1)
				fct_pkg::FUNC_SPHERE: hit_c[i] = (dist_c[i] > rad_sc);
				fct_pkg::FUNC_BOX:    hit_c[i] = (dist_c[i] > 0);
				fct_pkg::FUNC_POINT:  hit_c[i] = dist_c[i][fct_pkg::DIST_W-1];
				default:              hit_c[i] = 1'b0;
			endcase
		end
	end

	assign flags_nxt = flags_q & ~hit_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			flags_q     <= fct_pkg::FLAGS_ALL;
		end else if (en) begin
			valid_s1    <= head.valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2 && ((func_s2 != fct_pkg::FUNC_POINT) || last_s2);
			if (valid_s2 && (func_s2 == fct_pkg::FUNC_POINT)) begin
				flags_q <= last_s2 ? fct_pkg::FLAGS_ALL : flags_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1  <= head.item.func;
			last_s1  <= head.item.last;
			rad_s1   <= head.item.radius;
			prod_s1  <= prod_c;
			func_s2  <= func_s1;
			last_s2  <= last_s1;
			hit_s2   <= hit_c;
			culled_q <= (func_s2 == fct_pkg::FUNC_POINT) ? (|flags_nxt) : (|hit_s2);
		end
	end

	assign out_valid = out_valid_q;
	assign culled    = culled_q;

endmodule

[rtl/frustum_cull_test.sv]
// A sphere, box or last point-set transfer, once accepted, passes the queue and the
// stage-one, stage-two and output registers. Throughput: one item per cycle while the
// result side does not stall, set by the fully pipelined plane unit with 18 multipliers.
// A 4-entry queue keeps the input open while a result waits on the output register.
// Reset clears the plane registers to zero and sets all point-set flags.
module frustum_cull_test (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [fct_pkg::IDX_W-1:0]             wr_index,
	input  logic [fct_pkg::REG_W-1:0]             wr_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            func,
	input  logic signed [fct_pkg::COORD_WIDTH-1:0] point_x,
	input  logic signed [fct_pkg::COORD_WIDTH-1:0] point_y,
	input  logic signed [fct_pkg::COORD_WIDTH-1:0] point_z,
	input  logic signed [fct_pkg::COORD_WIDTH-1:0] box_max_x,
	input  logic signed [fct_pkg::COORD_WIDTH-1:0] box_max_y,
	input  logic signed [fct_pkg::COORD_WIDTH-1:0] box_max_z,
	input  logic [fct_pkg::COORD_WIDTH-2:0]        radius,
	input  logic                                  last,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  culled
);

	fct_pkg::plane_t  planes_q [fct_pkg::NUM_PLANES];
	fct_pkg::item_t   in_item;
	fct_pkg::q_head_t head;
	logic             pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
				planes_q[i] <= '0;
			end
		end else if (wr_en && (wr_index < fct_pkg::IDX_W'(fct_pkg::NUM_PLANES))) begin
			planes_q[wr_index] <= fct_pkg::plane_t'(wr_data);
		end
	end

	always_comb begin
		in_item.func   = fct_pkg::func_t'(func);
		in_item.px     = point_x;
		in_item.py     = point_y;
		in_item.pz     = point_z;
		in_item.hx     = box_max_x;
		in_item.hy     = box_max_y;
		in_item.hz     = box_max_z;
		in_item.radius = radius;
		in_item.last   = last;
	end

	fct_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.head     (head),
		.pop      (pop)
	);

	fct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.planes    (planes_q),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.culled    (culled)
	);

endmodule

[rtl/fct_checker.sv]
module fct_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic culled
);

	// A held result keeps its value until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(culled))
		else $error("held result changed before its transfer");

	// The input only stalls once the queue has filled behind a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(out_valid && out_stall))
		else $error("input stalled without a stalled result");

	// No result can appear sooner than the pipeline depth after reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3))
		else $error("result appeared too soon after reset");

endmodule

bind frustum_cull_test fct_checker u_fct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.culled    (culled)
);
